FILE: src/lcsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcsp_pkg: lane change speed planner definitions
// Opcodes, actions, register indexes, register reset values and the
// fixed-point constants of the planner.
// ----------------------------------------------------------------------------
package lcsp_pkg;

    // item opcodes
    localparam logic [1:0] OP_BEGIN   = 2'd0;
    localparam logic [1:0] OP_VEHICLE = 2'd1;
    localparam logic [1:0] OP_END     = 2'd2;

    // decision codes
    localparam logic [2:0] ACT_ACCEL  = 3'd0;
    localparam logic [2:0] ACT_CRUISE = 3'd1;
    localparam logic [2:0] ACT_LEFT   = 3'd2;
    localparam logic [2:0] ACT_RIGHT  = 3'd3;
    localparam logic [2:0] ACT_SLOW   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_HOLD_FRAMES    = 3'd0;
    localparam logic [2:0] CFG_SPEED_LIMIT    = 3'd1;
    localparam logic [2:0] CFG_ACCEL_STEP     = 3'd2;
    localparam logic [2:0] CFG_TURN_SLOW_STEP = 3'd3;
    localparam logic [2:0] CFG_STAY_SLOW_STEP = 3'd4;
    localparam logic [2:0] CFG_LANE_COUNT     = 3'd5;

    // register reset values
    localparam logic [7:0]  HOLD_FRAMES_RST    = 8'd50;
    localparam logic [10:0] SPEED_LIMIT_RST    = 11'd980;
    localparam logic [6:0]  ACCEL_STEP_RST     = 7'd10;
    localparam logic [6:0]  TURN_SLOW_STEP_RST = 7'd10;
    localparam logic [6:0]  STAY_SLOW_STEP_RST = 7'd7;
    localparam logic [2:0]  LANE_COUNT_RST     = 3'd3;

    // fixed-point constants, Q16 multipliers
    localparam logic signed [17:0] CLEAR_RESET  = 18'sd16000;
    localparam logic signed [17:0] SIDE_BEHIND  = -18'sd80;
    localparam logic [10:0]        GAP0_BASE    = 11'd480;
    localparam logic [27:0]        GAP0_Q16     = 28'd26214;
    localparam logic [27:0]        GAP1_Q16     = 28'd43946;
    localparam logic [28:0]        ANCHOR_Q16   = 29'd70313;
    localparam logic [27:0]        ROUND_HALF   = 28'd32768;
    localparam logic [10:0]        ANCHOR_MIN   = 11'd480;
    localparam logic [10:0]        ANCHOR_MAX   = 11'd1120;
    localparam logic signed [13:0] SPEED_FLOOR  = -14'sd4000;
    localparam logic [2:0]         LANES_MIN    = 3'd2;
    localparam logic [2:0]         LANES_MAX    = 3'd4;

endpackage
`default_nettype wire

FILE: src/lane_change_speed_planner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lane_change_speed_planner: frame-based highway lane and speed planner
// Takes a begin item with the ego state, one item per tracked vehicle and an
// end item, and at each end item gives the lane, target speed, anchor spacing,
// action and blocked flags.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel (i_in_valid / o_in_ready) carries opcode, pos_s, pos_d and
//    ego_speed; begin and vehicle transactions give no result, an end
//    transaction gives exactly one, opcode 3 is dropped
//  - output channel (o_out_valid / i_out_ready) carries one result transaction
//  - config channel (i_cfg_valid / o_cfg_ready) writes register i_cfg_index with
//    i_cfg_data; always ready; the user must use it only while idle (not enforced)
//  - an accepted item is held in the input register and evaluated against the
//    planner state; a result is loaded into the output register at the edge
//    on which its end item leaves the input register
//  - throughput is one item per cycle unless an end item is stalled, as below;
//    evaluation is combinational between input and result registers
//  - when the receiver stalls with a result pending, items that give no
//    result keep flowing; an end item waits in the input register and
//    o_in_ready drops until the pending result is taken
//  - synchronous reset clears the pipeline, loads the register defaults and
//    puts the planner in lane 1 with zero target speed
// ----------------------------------------------------------------------------
module lane_change_speed_planner (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [2:0]          i_cfg_index,
    input  wire  [10:0]         i_cfg_data,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire  [1:0]          i_opcode,
    input  wire  [16:0]         i_pos_s,
    input  wire  signed [10:0]  i_pos_d,
    input  wire  [10:0]         i_ego_speed,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic [1:0]          o_lane_index,
    output logic signed [12:0]  o_target_speed,
    output logic [10:0]         o_anchor_spacing,
    output logic [2:0]          o_action,
    output logic [2:0]          o_blocked_flags
);
    import lcsp_pkg::*;

    // configuration
    logic [7:0]  r_hold_frames;
    logic [10:0] r_speed_limit;
    logic [6:0]  r_accel_step;
    logic [6:0]  r_turn_slow_step;
    logic [6:0]  r_stay_slow_step;
    logic [2:0]  r_lane_count;

    // input register
    logic               r_v1;
    logic [1:0]         r_op;
    logic [16:0]        r_s;
    logic signed [10:0] r_d;
    logic [10:0]        r_spd;

    // planner state
    logic [1:0]         r_lane, n_lane;
    logic signed [12:0] r_speed, n_speed;
    logic [7:0]         r_frames, n_frames;
    logic [16:0]        r_ego_s, n_ego_s;
    logic signed [10:0] r_ego_d, n_ego_d;
    logic [10:0]        r_ego_spd, n_ego_spd;
    logic               r_ahead, n_ahead;
    logic               r_left, n_left;
    logic               r_right, n_right;
    logic signed [17:0] r_left_clear, n_left_clear;
    logic signed [17:0] r_right_clear, n_right_clear;

    // result register
    logic               r_out_valid;
    logic [1:0]         r_out_lane;
    logic signed [12:0] r_out_speed;
    logic [10:0]        r_out_spacing;
    logic [2:0]         r_out_action;
    logic [2:0]         r_out_flags;

    logic               w_advance;
    logic               w_proc;
    logic               w_proc_end;
    logic [2:0]         n_action;
    logic [10:0]        n_spacing;

    // vehicle path
    logic signed [17:0] w_ds;
    logic [27:0]        w_gap0_prod;
    logic [27:0]        w_gap1_prod;
    logic [10:0]        w_gap0;
    logic [10:0]        w_gap1;
    logic signed [11:0] w_d;
    logic signed [11:0] w_lo;
    logic               w_in_own;
    logic               w_in_left;
    logic               w_in_right;
    logic               w_side_ok;
    logic               w_near;

    // end path
    logic [2:0]         w_lanes;
    logic signed [11:0] w_e;
    logic signed [11:0] w_right_edge_lo;
    logic signed [11:0] w_right_edge_hi;
    logic               w_go_l;
    logic               w_go_r;
    logic               w_ok;
    logic signed [13:0] w_turn_v;
    logic signed [13:0] w_stay_v;
    logic signed [13:0] w_acc_v;
    logic [2:0]         w_right_lane;
    logic [28:0]        w_anc_prod;
    logic [12:0]        w_anc;

    assign o_cfg_ready = 1'b1;

    // an item leaves the input register unless it is an end item facing a full,
    // stalled result register
    assign w_advance  = !(r_op == OP_END) || !r_out_valid || i_out_ready;
    assign w_proc     = r_v1 && w_advance;
    assign w_proc_end = w_proc && (r_op == OP_END);
    assign o_in_ready = !r_v1 || w_advance;

    // speed-scaled gaps, round to nearest
    assign w_gap0_prod = {17'b0, r_ego_spd} * GAP0_Q16 + ROUND_HALF;
    assign w_gap1_prod = {17'b0, r_ego_spd} * GAP1_Q16 + ROUND_HALF;
    assign w_gap0      = GAP0_BASE + w_gap0_prod[26:16];
    assign w_gap1      = w_gap1_prod[26:16];

    assign w_ds  = $signed({1'b0, r_s}) - $signed({1'b0, r_ego_s});
    assign w_d   = {r_d[10], r_d};
    assign w_lo  = $signed({4'b0, r_lane, 6'b0});
    assign w_in_own   = (w_d >= w_lo) && (w_d < w_lo + 12'sd64);
    assign w_in_left  = (w_d >= w_lo - 12'sd64) && (w_d < w_lo);
    assign w_in_right = (w_d >= w_lo + 12'sd64) && (w_d < w_lo + 12'sd128);
    assign w_side_ok  = w_ds > SIDE_BEHIND;
    assign w_near     = w_ds < $signed({7'b0, w_gap1});

    // effective lane count and road edges
    always_comb begin
        if (r_lane_count < LANES_MIN) begin
            w_lanes = LANES_MIN;
        end else if (r_lane_count > LANES_MAX) begin
            w_lanes = LANES_MAX;
        end else begin
            w_lanes = r_lane_count;
        end
    end

    assign w_e             = {r_ego_d[10], r_ego_d};
    assign w_right_edge_lo = $signed({3'b0, w_lanes - 3'd1, 6'b0});
    assign w_right_edge_hi = $signed({3'b0, w_lanes, 6'b0});

    always_comb begin
        w_go_l = 1'b0;
        w_go_r = 1'b0;
        if (w_e >= 12'sd0 && w_e <= 12'sd64) begin
            w_go_r = !r_right;
        end else if (w_e >= w_right_edge_lo && w_e <= w_right_edge_hi) begin
            w_go_l = !r_left;
        end else if (!r_left && !r_right) begin
            if (r_left_clear > r_right_clear) begin
                w_go_l = 1'b1;
            end else begin
                w_go_r = 1'b1;
            end
        end else if (!r_left) begin
            w_go_l = 1'b1;
        end else if (!r_right) begin
            w_go_r = 1'b1;
        end
    end

    assign w_ok     = r_frames >= r_hold_frames;
    assign w_turn_v = {r_speed[12], r_speed} - $signed({7'b0, r_turn_slow_step});
    assign w_stay_v = {r_speed[12], r_speed} - $signed({7'b0, r_stay_slow_step});
    assign w_acc_v  = {r_speed[12], r_speed} + $signed({7'b0, r_accel_step});

    // move right clamps to the last lane
    always_comb begin
        if ({1'b0, r_lane} + 3'd1 > w_lanes - 3'd1) begin
            w_right_lane = w_lanes - 3'd1;
        end else begin
            w_right_lane = {1'b0, r_lane} + 3'd1;
        end
    end

    // next state
    always_comb begin
        n_lane        = r_lane;
        n_speed       = r_speed;
        n_frames      = r_frames;
        n_ego_s       = r_ego_s;
        n_ego_d       = r_ego_d;
        n_ego_spd     = r_ego_spd;
        n_ahead       = r_ahead;
        n_left        = r_left;
        n_right       = r_right;
        n_left_clear  = r_left_clear;
        n_right_clear = r_right_clear;
        n_action      = ACT_CRUISE;
        if (w_proc) begin
            case (r_op)
                OP_BEGIN: begin
                    n_ego_s       = r_s;
                    n_ego_d       = r_d;
                    n_ego_spd     = r_spd;
                    n_ahead       = 1'b0;
                    n_left        = 1'b0;
                    n_right       = 1'b0;
                    n_left_clear  = CLEAR_RESET;
                    n_right_clear = CLEAR_RESET;
                    if (r_frames != 8'd255) begin
                        n_frames = r_frames + 8'd1;
                    end
                end
                OP_VEHICLE: begin
                    if (w_in_own && w_ds > 18'sd0 && w_ds < $signed({7'b0, w_gap0})) begin
                        n_ahead = 1'b1;
                    end
                    if (w_in_left && w_side_ok) begin
                        if (w_near) begin
                            n_left = 1'b1;
                        end
                        if (w_ds < r_left_clear) begin
                            n_left_clear = w_ds;
                        end
                    end
                    if (w_in_right && w_side_ok) begin
                        if (w_near) begin
                            n_right = 1'b1;
                        end
                        if (w_ds < r_right_clear) begin
                            n_right_clear = w_ds;
                        end
                    end
                end
                OP_END: begin
                    if (r_ahead) begin
                        if (w_ok && (w_go_l || w_go_r)) begin
                            n_speed  = (w_turn_v < SPEED_FLOOR) ? SPEED_FLOOR[12:0]
                                                                : w_turn_v[12:0];
                            n_frames = 8'd0;
                            if (w_go_l) begin
                                n_lane   = (r_lane != 2'd0) ? r_lane - 2'd1 : 2'd0;
                                n_action = ACT_LEFT;
                            end else begin
                                n_lane   = w_right_lane[1:0];
                                n_action = ACT_RIGHT;
                            end
                        end else begin
                            n_speed  = (w_stay_v < SPEED_FLOOR) ? SPEED_FLOOR[12:0]
                                                                : w_stay_v[12:0];
                            n_action = ACT_SLOW;
                        end
                    end else if (r_speed < $signed({2'b0, r_speed_limit})) begin
                        n_speed  = w_acc_v[12:0];
                        n_action = ACT_ACCEL;
                    end else begin
                        n_action = ACT_CRUISE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // anchor spacing from the updated target speed
    assign w_anc_prod = {17'b0, n_speed[11:0]} * ANCHOR_Q16 + {1'b0, ROUND_HALF};
    assign w_anc      = w_anc_prod[28:16];

    always_comb begin
        if (n_speed <= 13'sd0) begin
            n_spacing = ANCHOR_MIN;
        end else if (w_anc < {2'b0, ANCHOR_MIN}) begin
            n_spacing = ANCHOR_MIN;
        end else if (w_anc > {2'b0, ANCHOR_MAX}) begin
            n_spacing = ANCHOR_MAX;
        end else begin
            n_spacing = w_anc[10:0];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_frames    <= HOLD_FRAMES_RST;
            r_speed_limit    <= SPEED_LIMIT_RST;
            r_accel_step     <= ACCEL_STEP_RST;
            r_turn_slow_step <= TURN_SLOW_STEP_RST;
            r_stay_slow_step <= STAY_SLOW_STEP_RST;
            r_lane_count     <= LANE_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HOLD_FRAMES:    r_hold_frames    <= i_cfg_data[7:0];
                CFG_SPEED_LIMIT:    r_speed_limit    <= i_cfg_data;
                CFG_ACCEL_STEP:     r_accel_step     <= i_cfg_data[6:0];
                CFG_TURN_SLOW_STEP: r_turn_slow_step <= i_cfg_data[6:0];
                CFG_STAY_SLOW_STEP: r_stay_slow_step <= i_cfg_data[6:0];
                CFG_LANE_COUNT:     r_lane_count     <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_in_ready) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op  <= i_opcode;
            r_s   <= i_pos_s;
            r_d   <= i_pos_d;
            r_spd <= i_ego_speed;
        end
    end

    // planner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane        <= 2'd1;
            r_speed       <= 13'sd0;
            r_frames      <= 8'd0;
            r_ego_s       <= 17'd0;
            r_ego_d       <= 11'sd0;
            r_ego_spd     <= 11'd0;
            r_ahead       <= 1'b0;
            r_left        <= 1'b0;
            r_right       <= 1'b0;
            r_left_clear  <= CLEAR_RESET;
            r_right_clear <= CLEAR_RESET;
        end else begin
            r_lane        <= n_lane;
            r_speed       <= n_speed;
            r_frames      <= n_frames;
            r_ego_s       <= n_ego_s;
            r_ego_d       <= n_ego_d;
            r_ego_spd     <= n_ego_spd;
            r_ahead       <= n_ahead;
            r_left        <= n_left;
            r_right       <= n_right;
            r_left_clear  <= n_left_clear;
            r_right_clear <= n_right_clear;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc_end) begin
            r_out_lane    <= n_lane;
            r_out_speed   <= n_speed;
            r_out_spacing <= n_spacing;
            r_out_action  <= n_action;
            r_out_flags   <= {r_right, r_left, r_ahead};
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_lane_index     = r_out_lane;
    assign o_target_speed   = r_out_speed;
    assign o_anchor_spacing = r_out_spacing;
    assign o_action         = r_out_action;
    assign o_blocked_flags  = r_out_flags;

    // input stalls only behind a pending result that is not being taken
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v1 && r_out_valid && !i_out_ready))
        else $error("input stalled without a pending result");

    // a lane change restarts the hold counter
    a_change_resets_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc_end && (n_action == ACT_LEFT || n_action == ACT_RIGHT))
        |=> (r_frames == 8'd0 && (o_action == ACT_LEFT || o_action == ACT_RIGHT)))
        else $error("lane change did not restart hold counter");

    // a begin item clears the per-frame findings
    a_begin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_op == OP_BEGIN)
        |=> (!r_ahead && !r_left && !r_right && r_left_clear == CLEAR_RESET
             && r_right_clear == CLEAR_RESET))
        else $error("frame begin did not clear findings");

endmodule
`default_nettype wire
